// ===== rtl/bocu1e_pkg.sv =====
package bocu1e_pkg;

    // Field widths.
    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;

    // Width of the offset within a difference range; it stays below 243**3.
    localparam int V_W = 24;

    // One code point after range selection: offset, trail count and lead.
    // With trail bytes the lead holds the range's first lead byte; for one or two
    // trail bytes the high digit of the offset is added to it later.
    typedef struct packed {
        logic [V_W-1:0]    v;
        logic [1:0]        n_trail;
        logic [BYTE_W-1:0] lead;
    } t_job;

    // A finished byte run: lead byte at index 0, trail bytes after it.
    typedef struct packed {
        logic [3:0][BYTE_W-1:0] run_bytes;
        logic [1:0]             n_trail;
    } t_run;

endpackage

// ===== rtl/bocu1e_if.sv =====
// Input channel: one code point per word.
interface bocu1e_in_if;
    logic                           valid;
    logic                           ready;
    logic [bocu1e_pkg::CP_W-1:0]    code_point;
    logic                           end_of_text;

    modport source (output valid, code_point, end_of_text, input ready);
    modport sink   (input valid, code_point, end_of_text, output ready);
endinterface

// Output channel: one encoded byte per word.
interface bocu1e_out_if;
    logic                           valid;
    logic                           ready;
    logic [bocu1e_pkg::BYTE_W-1:0]  out_byte;
    logic                           last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== rtl/bocu1e_front.sv =====
module bocu1e_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bocu1e_in_if.sink          i_in,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output bocu1e_pkg::t_job   o_job
);
    import bocu1e_pkg::*;

    // Difference range limits.
    localparam logic signed [24:0] REACH_NEG3 = -25'sd14536567;
    localparam logic signed [24:0] REACH_NEG2 = -25'sd187660;
    localparam logic signed [24:0] REACH_NEG1 = -25'sd10513;
    localparam logic signed [24:0] REACH_NEG0 = -25'sd64;
    localparam logic signed [24:0] REACH_POS0 = 25'sd64;
    localparam logic signed [24:0] REACH_POS1 = 25'sd10513;
    localparam logic signed [24:0] REACH_POS2 = 25'sd187660;

    // First lead byte of each range.
    localparam logic [BYTE_W-1:0] LEAD_NEG3 = 8'h21;
    localparam logic [BYTE_W-1:0] LEAD_NEG2 = 8'h22;
    localparam logic [BYTE_W-1:0] LEAD_NEG1 = 8'h25;
    localparam logic [BYTE_W-1:0] LEAD_MID  = 8'h90;
    localparam logic [BYTE_W-1:0] LEAD_POS1 = 8'hD0;
    localparam logic [BYTE_W-1:0] LEAD_POS2 = 8'hFB;
    localparam logic [BYTE_W-1:0] LEAD_POS3 = 8'hFE;

    localparam logic [CP_W-1:0] BASE_RESET = 21'h40;
    localparam logic [CP_W-1:0] CP_SPACE   = 21'h20;

    logic                    r_vld;
    logic [CP_W-1:0]         r_code;
    logic                    r_eot;
    logic [CP_W-1:0]         r_base;
    logic [CP_W-1:0]         n_base;
    logic signed [24:0]      diff;
    t_job                    job;

    // The input register takes a word whenever it is free or moving on.
    assign i_in.ready = !r_vld || i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_code <= i_in.code_point;
            r_eot  <= i_in.end_of_text;
        end
    end

    // The base moves on as the held code point leaves this stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (r_vld && i_job_ready) begin
            r_base <= n_base;
        end
    end

    assign diff = $signed({4'b0000, r_code}) - $signed({4'b0000, r_base});

    // Pick the difference range, its offset and its lead byte.
    always_comb begin
        job = '0;
        if (r_code <= CP_SPACE) begin
            job.lead = r_code[BYTE_W-1:0];
        end else begin
            priority if (diff < REACH_NEG2) begin
                job.v       = V_W'(diff - REACH_NEG3);
                job.lead    = LEAD_NEG3;
                job.n_trail = 2'd3;
            end else if (diff < REACH_NEG1) begin
                job.v       = V_W'(diff - REACH_NEG2);
                job.lead    = LEAD_NEG2;
                job.n_trail = 2'd2;
            end else if (diff < REACH_NEG0) begin
                job.v       = V_W'(diff - REACH_NEG1);
                job.lead    = LEAD_NEG1;
                job.n_trail = 2'd1;
            end else if (diff < REACH_POS0) begin
                job.lead    = diff[BYTE_W-1:0] + LEAD_MID;
            end else if (diff < REACH_POS1) begin
                job.v       = V_W'(diff - REACH_POS0);
                job.lead    = LEAD_POS1;
                job.n_trail = 2'd1;
            end else if (diff < REACH_POS2) begin
                job.v       = V_W'(diff - REACH_POS1);
                job.lead    = LEAD_POS2;
                job.n_trail = 2'd2;
            end else begin
                job.v       = V_W'(diff - REACH_POS2);
                job.lead    = LEAD_POS3;
                job.n_trail = 2'd3;
            end
        end
    end

    // Next base: 0x40 on end of text or below space, kept on space, script midpoints, else mid 128-value block.
    always_comb begin
        priority if (r_eot) begin
            n_base = BASE_RESET;
        end else if (r_code < CP_SPACE) begin
            n_base = BASE_RESET;
        end else if (r_code == CP_SPACE) begin
            n_base = r_base;
        end else if (r_code >= 21'h3040 && r_code <= 21'h309F) begin
            n_base = 21'h3070;
        end else if (r_code >= 21'h4E00 && r_code <= 21'h9FA5) begin
            n_base = 21'h7711;
        end else if (r_code >= 21'hAC00 && r_code <= 21'hD7A3) begin
            n_base = 21'hC1D1;
        end else begin
            n_base = {r_code[CP_W-1:7], 7'h40};
        end
    end

    assign o_job_valid = r_vld;
    assign o_job       = job;

endmodule

// ===== rtl/bocu1e_digits.sv =====
module bocu1e_digits (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_ready,
    input  bocu1e_pkg::t_job   i_job,
    output logic               o_run_valid,
    input  logic               i_run_ready,
    output bocu1e_pkg::t_run   o_run
);
    import bocu1e_pkg::*;

    // floor(x / 243) = (x * DIV_MUL) >> DIV_SHIFT for any x below 2**24.
    localparam logic [24:0] DIV_MUL   = 25'd17674763;
    localparam int          DIV_SHIFT = 32;

    // Map a base-243 digit to a byte that skips the control bytes.
    function automatic logic [BYTE_W-1:0] trail_map(input logic [BYTE_W-1:0] t);
        logic [BYTE_W-1:0] b;
        priority if (t < 8'd6) begin
            b = t + 8'd1;
        end else if (t < 8'd16) begin
            b = t + 8'd10;
        end else if (t < 8'd20) begin
            b = t + 8'd12;
        end else begin
            b = t + 8'd13;
        end
        return b;
    endfunction

    logic                 r_s1_vld;
    t_job                 r_s1_job;
    logic                 r_s2_vld;
    logic [BYTE_W-1:0]    r_s2_vlo;
    logic [15:0]          r_s2_q1;
    logic [1:0]           r_s2_n;
    logic [BYTE_W-1:0]    r_s2_lead;
    logic                 r_s3_vld;
    logic [BYTE_W-1:0]    r_s3_d0;
    logic [15:0]          r_s3_q1;
    logic [BYTE_W-1:0]    r_s3_q2;
    logic [1:0]           r_s3_n;
    logic [BYTE_W-1:0]    r_s3_lead;

    logic                 rdy1;
    logic                 rdy2;
    logic                 rdy3;
    logic [48:0]          prod1;
    logic [40:0]          prod2;
    logic [15:0]          n_q1;
    logic [BYTE_W-1:0]    n_q2;
    logic [BYTE_W-1:0]    n_d0;
    logic [BYTE_W-1:0]    d1;
    t_run                 run;

    // Each stage moves when the one after it is free or moving.
    assign rdy3        = !r_s3_vld || i_run_ready;
    assign rdy2        = !r_s2_vld || rdy3;
    assign rdy1        = !r_s1_vld || rdy2;
    assign o_job_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_vld <= i_job_valid;
            end
            if (rdy2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (rdy3) begin
                r_s3_vld <= r_s2_vld;
            end
        end
    end

    // First divide: the offset by 243.
    assign prod1 = 49'(r_s1_job.v) * 49'(DIV_MUL);
    assign n_q1  = 16'(prod1 >> DIV_SHIFT);

    // Second divide and the low digit, from the first quotient.
    assign prod2 = 41'(r_s2_q1) * 41'(DIV_MUL);
    assign n_q2  = BYTE_W'(prod2 >> DIV_SHIFT);
    assign n_d0  = r_s2_vlo - BYTE_W'(r_s2_q1 * 16'd243);

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_job <= i_job;
        end
        if (rdy2) begin
            r_s2_vlo  <= r_s1_job.v[BYTE_W-1:0];
            r_s2_q1   <= n_q1;
            r_s2_n    <= r_s1_job.n_trail;
            r_s2_lead <= r_s1_job.lead;
        end
        if (rdy3) begin
            r_s3_d0   <= n_d0;
            r_s3_q1   <= r_s2_q1;
            r_s3_q2   <= n_q2;
            r_s3_n    <= r_s2_n;
            r_s3_lead <= r_s2_lead;
        end
    end

    // Middle digit; then place lead and trail bytes in sending order.
    assign d1 = r_s3_q1[BYTE_W-1:0] - BYTE_W'(r_s3_q2 * 8'd243);

    always_comb begin
        run         = '0;
        run.n_trail = r_s3_n;
        unique case (r_s3_n)
            2'd0: begin
                run.run_bytes[0] = r_s3_lead;
            end
            2'd1: begin
                run.run_bytes[0] = r_s3_lead + r_s3_q1[BYTE_W-1:0];
                run.run_bytes[1] = trail_map(r_s3_d0);
            end
            2'd2: begin
                run.run_bytes[0] = r_s3_lead + r_s3_q2;
                run.run_bytes[1] = trail_map(d1);
                run.run_bytes[2] = trail_map(r_s3_d0);
            end
            default: begin
                run.run_bytes[0] = r_s3_lead;
                run.run_bytes[1] = trail_map(r_s3_q2);
                run.run_bytes[2] = trail_map(d1);
                run.run_bytes[3] = trail_map(r_s3_d0);
            end
        endcase
    end

    assign o_run_valid = r_s3_vld;
    assign o_run       = run;

endmodule

// ===== rtl/bocu1e_serial.sv =====
module bocu1e_serial (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_run_valid,
    output logic               o_run_ready,
    input  bocu1e_pkg::t_run   i_run,
    bocu1e_out_if.source       o_out
);
    import bocu1e_pkg::*;

    logic                 r_busy;
    t_run                 r_run;
    logic [1:0]           r_idx;
    logic                 r_out_vld;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_last;
    logic                 out_free;
    logic                 is_last;

    assign out_free    = !r_out_vld || o_out.ready;
    assign is_last     = (r_idx == r_run.n_trail);
    // A new run may enter as the last byte of the held one goes out.
    assign o_run_ready = !r_busy || (out_free && is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_run_ready) begin
            r_busy <= i_run_valid;
            r_idx  <= 2'd0;
        end else if (r_busy && out_free) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_run_ready && i_run_valid) begin
            r_run <= i_run;
        end
    end

    // Output register: one byte per word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && out_free) begin
            r_out_byte <= r_run.run_bytes[r_idx];
            r_out_last <= is_last;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.last_byte = r_out_last;

endmodule

// ===== rtl/bocu1_encoder_core.sv =====
// Channel  Dir  Word                          Handshake
// i_in     in   code_point[20:0], end_of_text  valid / ready
// o_out    out  out_byte[7:0], last_byte       valid / ready
//
// A code point gives a run of 1 to 4 bytes, one byte per cycle while the
// output is not stalled; the byte serializer in front of the output register
// sets that rate. A word passes the front, digit and serializer registers in turn.
// Reset clears all valid flags and sets the base to 0x40.
// A stalled output holds its word; the pipeline keeps filling behind it.
module bocu1_encoder_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bocu1e_in_if.sink     i_in,
    bocu1e_out_if.source  o_out
);
    import bocu1e_pkg::*;

    logic  job_valid;
    logic  job_ready;
    t_job  job;
    logic  run_valid;
    logic  run_ready;
    t_run  run;

    // Input register, range selection and base tracking.
    bocu1e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    // Base-243 digit pipeline.
    bocu1e_digits u_digits (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_run_valid (run_valid),
        .i_run_ready (run_ready),
        .o_run       (run)
    );

    // Byte serializer and output register.
    bocu1e_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_valid (run_valid),
        .o_run_ready (run_ready),
        .i_run       (run),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/bocu1e_checker.sv =====
module bocu1e_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_out_byte,
    input logic        i_out_last
);

    // High while the words of a run after its lead byte are due.
    logic r_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_mid <= !i_out_last;
        end
    end

    // A stalled word stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word withdrawn while stalled");

    // A stalled word keeps its payload.
    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output word changed while stalled");

    // Nothing is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // The lead byte of a multi-byte run lies in a difference range.
    a_lead_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !r_mid && !i_out_last |->
            (i_out_byte >= 8'h21 && i_out_byte <= 8'h4F) ||
            (i_out_byte >= 8'hD0 && i_out_byte <= 8'hFE))
        else $error("bad lead byte for a multi-byte run");

    // Trail bytes never take a control byte value.
    a_trail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_mid |->
            i_out_byte != 8'h00 && i_out_byte != 8'h1A && i_out_byte != 8'h1B &&
            i_out_byte != 8'h20 && !(i_out_byte >= 8'h07 && i_out_byte <= 8'h0F))
        else $error("trail byte is a control byte");

endmodule

bind bocu1_encoder_core bocu1e_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last_byte)
);
